[design/ncet_pkg.sv]
// Shared types and constants of the navigation cell exit test.
package ncet_pkg;

   localparam int POINT_BITS    = 21;
   localparam int VERTEX_BITS   = 63;
   localparam int MAT_BITS      = 18;
   localparam int MATRIX_BITS   = 54;
   localparam int LINK_BITS     = 16;
   localparam int LINKS_BITS    = 48;
   localparam int NUM_EDGES     = 3;
   localparam int NUM_AXES      = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_INDEX_LSB = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - CSR_INDEX_LSB;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_VERTEX_A       = 3'd0;
   localparam csr_index_type REG_VERTEX_B       = 3'd1;
   localparam csr_index_type REG_VERTEX_C       = 3'd2;
   localparam csr_index_type REG_MATRIX_ROW_X   = 3'd3;
   localparam csr_index_type REG_MATRIX_ROW_Z   = 3'd4;
   localparam csr_index_type REG_NEIGHBOR_LINKS = 3'd5;

   localparam logic [VERTEX_BITS-1:0] VERTEX_RESET       = '0;
   localparam logic [MATRIX_BITS-1:0] MATRIX_ROW_X_RESET = 54'd65536;
   localparam logic [MATRIX_BITS-1:0] MATRIX_ROW_Z_RESET = 54'd4294967296;
   localparam logic [LINKS_BITS-1:0]  LINKS_RESET        = '1;

   typedef logic signed [MAT_BITS-1:0]  mat_entry_type;
   typedef logic signed [LINK_BITS-1:0] link_type;

   localparam link_type NO_NEIGHBOR = '1;

   typedef struct packed {
      link_type neighbor_index;
      logic     is_out;
   } rsp_type;

endpackage

[design/ncet_setup.sv]
// Stage one: edge deltas and point offsets from each edge's start vertex.
module ncet_setup #(
   parameter int COORD_BITS = 21,
   localparam int DW = COORD_BITS + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance_i,
   input  logic                                  in_valid_i,
   input  logic [ncet_pkg::POINT_BITS-1:0]       point_i  [ncet_pkg::NUM_AXES],
   input  logic [ncet_pkg::VERTEX_BITS-1:0]      vertex_i [ncet_pkg::NUM_EDGES],
   output logic                                  out_valid_o,
   output logic signed [DW-1:0]                  dx_o     [ncet_pkg::NUM_EDGES],
   output logic signed [DW-1:0]                  dz_o     [ncet_pkg::NUM_EDGES],
   output logic signed [DW-1:0]                  diff_o   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES]
);

   logic                 valid_ff;
   logic signed [DW-1:0] dx_in   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] dz_in   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] diff_in [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [DW-1:0] dx_ff   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] dz_ff   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] diff_ff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];

   for (genvar e = 0; e < ncet_pkg::NUM_EDGES; e++) begin : g_edge
      localparam int EN = (e + 1) % ncet_pkg::NUM_EDGES;
      logic signed [COORD_BITS-1:0] sx, sz, fx, fz;

      assign sx = signed'(vertex_i[e][0 +: COORD_BITS]);
      assign sz = signed'(vertex_i[e][2*COORD_BITS +: COORD_BITS]);
      assign fx = signed'(vertex_i[EN][0 +: COORD_BITS]);
      assign fz = signed'(vertex_i[EN][2*COORD_BITS +: COORD_BITS]);
      assign dx_in[e] = DW'(fx) - DW'(sx);
      assign dz_in[e] = DW'(fz) - DW'(sz);

      for (genvar k = 0; k < ncet_pkg::NUM_AXES; k++) begin : g_axis
         logic signed [COORD_BITS-1:0] pk, sk;
         assign pk = signed'(point_i[k][COORD_BITS-1:0]);
         assign sk = signed'(vertex_i[e][k*COORD_BITS +: COORD_BITS]);
         assign diff_in[e][k] = DW'(pk) - DW'(sk);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance_i) begin
         valid_ff <= in_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_i) begin
         dx_ff   <= dx_in;
         dz_ff   <= dz_in;
         diff_ff <= diff_in;
      end
   end

   assign out_valid_o = valid_ff;
   assign dx_o        = dx_ff;
   assign dz_o        = dz_ff;
   assign diff_o      = diff_ff;

endmodule

[design/ncet_xform.sv]
// Stages two and three: edge normals carried through the world matrix rows.
module ncet_xform #(
   parameter int COORD_BITS = 21,
   localparam int DW = COORD_BITS + 1,
   localparam int PW = DW + ncet_pkg::MAT_BITS,
   localparam int TW = PW + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance_i,
   input  logic                            in_valid_i,
   input  logic signed [DW-1:0]            dx_i     [ncet_pkg::NUM_EDGES],
   input  logic signed [DW-1:0]            dz_i     [ncet_pkg::NUM_EDGES],
   input  logic signed [DW-1:0]            diff_i   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES],
   input  ncet_pkg::mat_entry_type         mat_x_i  [ncet_pkg::NUM_AXES],
   input  ncet_pkg::mat_entry_type         mat_z_i  [ncet_pkg::NUM_AXES],
   output logic                            out_valid_o,
   output logic signed [TW-1:0]            t_o      [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES],
   output logic signed [DW-1:0]            diff_o   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES]
);

   logic                 valid2_ff, valid3_ff;
   logic signed [PW-1:0] pdx_in  [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [PW-1:0] pdz_in  [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [PW-1:0] pdx_ff  [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [PW-1:0] pdz_ff  [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [TW-1:0] t_in    [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [TW-1:0] t_ff    [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [DW-1:0] diff2_ff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [DW-1:0] diff3_ff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];

   // normal is (-dz, dx): t = dx * row_z - dz * row_x
   for (genvar e = 0; e < ncet_pkg::NUM_EDGES; e++) begin : g_edge
      for (genvar k = 0; k < ncet_pkg::NUM_AXES; k++) begin : g_axis
         assign pdx_in[e][k] = PW'(dx_i[e]) * PW'(mat_z_i[k]);
         assign pdz_in[e][k] = PW'(dz_i[e]) * PW'(mat_x_i[k]);
         assign t_in[e][k]   = TW'(pdx_ff[e][k]) - TW'(pdz_ff[e][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance_i) begin
         valid2_ff <= in_valid_i;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_i) begin
         pdx_ff   <= pdx_in;
         pdz_ff   <= pdz_in;
         diff2_ff <= diff_i;
         t_ff     <= t_in;
         diff3_ff <= diff2_ff;
      end
   end

   assign out_valid_o = valid3_ff;
   assign t_o         = t_ff;
   assign diff_o      = diff3_ff;

endmodule

[design/ncet_dot.sv]
// Stages four to six: split dot products, term sums, edge signs and first failing edge.
module ncet_dot #(
   parameter int COORD_BITS = 21,
   localparam int DW  = COORD_BITS + 1,
   localparam int TW  = DW + ncet_pkg::MAT_BITS + 1,
   localparam int TLO = TW / 2,
   localparam int THI = TW - TLO,
   localparam int LW  = TLO + 1 + DW,
   localparam int HW  = THI + DW,
   localparam int XW  = TW + DW,
   localparam int EW  = XW + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance_i,
   input  logic                     in_valid_i,
   input  logic signed [TW-1:0]     t_i     [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES],
   input  logic signed [DW-1:0]     diff_i  [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES],
   input  ncet_pkg::link_type       links_i [ncet_pkg::NUM_EDGES],
   output logic                     out_valid_o,
   output ncet_pkg::rsp_type        out_data_o
);

   logic                 valid4_ff, valid5_ff, valid6_ff;
   logic signed [LW-1:0] lo_in   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [HW-1:0] hi_in   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [LW-1:0] lo_ff   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [HW-1:0] hi_ff   [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [XW-1:0] term_in [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [XW-1:0] term_ff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [EW-1:0] dot_in  [ncet_pkg::NUM_EDGES];
   logic [ncet_pkg::NUM_EDGES-1:0] pos_in, pos_ff;

   for (genvar e = 0; e < ncet_pkg::NUM_EDGES; e++) begin : g_edge
      for (genvar k = 0; k < ncet_pkg::NUM_AXES; k++) begin : g_axis
         logic signed [TLO:0]   t_lo;
         logic signed [THI-1:0] t_hi;
         assign t_lo = signed'({1'b0, t_i[e][k][TLO-1:0]});
         assign t_hi = signed'(t_i[e][k][TW-1:TLO]);
         assign lo_in[e][k]   = LW'(t_lo) * LW'(diff_i[e][k]);
         assign hi_in[e][k]   = HW'(t_hi) * HW'(diff_i[e][k]);
         assign term_in[e][k] = (XW'(hi_ff[e][k]) <<< TLO) + XW'(lo_ff[e][k]);
      end
      assign dot_in[e] = EW'(term_ff[e][0]) + EW'(term_ff[e][1]) + EW'(term_ff[e][2]);
      assign pos_in[e] = !dot_in[e][EW-1] && (dot_in[e] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else if (advance_i) begin
         valid4_ff <= in_valid_i;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_i) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         term_ff <= term_in;
         pos_ff  <= pos_in;
      end
   end

   always_comb begin
      out_data_o.is_out         = |pos_ff;
      out_data_o.neighbor_index = ncet_pkg::NO_NEIGHBOR;
      if (pos_ff[0]) begin
         out_data_o.neighbor_index = links_i[0];
      end else if (pos_ff[1]) begin
         out_data_o.neighbor_index = links_i[1];
      end else if (pos_ff[2]) begin
         out_data_o.neighbor_index = links_i[2];
      end
   end

   assign out_valid_o = valid6_ff;

endmodule

[design/ncet_skid.sv]
// Output register with a spare entry that decouples the pipeline from the receiver.
module ncet_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid_i,
   input  ncet_pkg::rsp_type in_data_i,
   output logic              in_ready_o,
   output logic              out_valid_o,
   output ncet_pkg::rsp_type out_data_o,
   input  logic              out_ready_i
);

   logic              out_valid_ff, spare_valid_ff;
   ncet_pkg::rsp_type out_data_ff, spare_data_ff;
   logic              push;

   assign in_ready_o = !spare_valid_ff;
   assign push       = in_valid_i && !spare_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (out_ready_i || !out_valid_ff) begin
         if (spare_valid_ff) begin
            out_valid_ff   <= 1'b1;
            spare_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         spare_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready_i || !out_valid_ff) begin
         out_data_ff <= spare_valid_ff ? spare_data_ff : in_data_i;
      end else if (push) begin
         spare_data_ff <= in_data_i;
      end
   end

   assign out_valid_o = out_valid_ff;
   assign out_data_o  = out_data_ff;

`ifndef SYNTHESIS
   a_spare_needs_out: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> out_valid_ff)
      else $error("spare entry held while output empty");

   a_spare_moves_up: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff && out_ready_i |=> out_valid_ff && out_data_ff == $past(spare_data_ff))
      else $error("spare beat not forwarded");

   a_stall_catch: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready_i && !spare_valid_ff && in_valid_i |=> spare_valid_ff)
      else $error("beat lost during stall");
`endif

endmodule

[design/navmesh_cell_exit_test.sv]
// Top level of the navigation cell exit test with its register file.
//
// Tests a query point against one navigation triangle held in registers.
// req channel: one beat carries point x, y, z; rsp channel: one beat carries
// the outside flag and the neighbour across the first failing edge (AB, BC,
// CA in that order), or -1 when the point lies inside or on every edge.
// csr port: 64-bit registers at byte address 8*i: vertex a, b, c, matrix
// rows x and z, neighbour links. Write them only while no beat is in flight.
// Throughput: one beat per cycle while req_tready is high, through the six-stage
// multiply pipeline (deltas, normal products, transform sum, split dot products,
// term sums, edge signs) followed by the output register.
// Path: a req beat passes these stages and then the output register before its
// result shows on rsp_tvalid; a stall holds it on the way.
// Reset: empties the pipeline and the output, and loads the register
// defaults (zero vertices, default matrix rows, no neighbours).
// Stall: the output register and a spare entry keep two beats; while the
// spare is full req_tready drops and the pipeline holds, nothing is lost.
module navmesh_cell_exit_test #(
   parameter int COORD_BITS = 21
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_x, point_y, point_z
   input  logic [63:0]                          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // is_out, neighbor_index
   output logic [23:0]                          rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ncet_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ncet_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ncet_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int DW = COORD_BITS + 1;
   localparam int TW = DW + ncet_pkg::MAT_BITS + 1;

   logic [ncet_pkg::VERTEX_BITS-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [ncet_pkg::MATRIX_BITS-1:0] matrix_row_x_ff, matrix_row_z_ff;
   logic [ncet_pkg::LINKS_BITS-1:0]  neighbor_links_ff;
   logic                             csr_write;
   ncet_pkg::csr_index_type          csr_index;

   logic [ncet_pkg::POINT_BITS-1:0]  point    [ncet_pkg::NUM_AXES];
   logic [ncet_pkg::VERTEX_BITS-1:0] vertex   [ncet_pkg::NUM_EDGES];
   ncet_pkg::mat_entry_type          mat_x    [ncet_pkg::NUM_AXES];
   ncet_pkg::mat_entry_type          mat_z    [ncet_pkg::NUM_AXES];
   ncet_pkg::link_type               links    [ncet_pkg::NUM_EDGES];

   logic                 advance;
   logic                 s1_valid, s3_valid, s6_valid;
   logic signed [DW-1:0] s1_dx   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] s1_dz   [ncet_pkg::NUM_EDGES];
   logic signed [DW-1:0] s1_diff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [TW-1:0] s3_t    [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   logic signed [DW-1:0] s3_diff [ncet_pkg::NUM_EDGES][ncet_pkg::NUM_AXES];
   ncet_pkg::rsp_type    s6_data, rsp_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[ncet_pkg::CSR_ADDR_BITS-1:ncet_pkg::CSR_INDEX_LSB];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff       <= ncet_pkg::VERTEX_RESET;
         vertex_b_ff       <= ncet_pkg::VERTEX_RESET;
         vertex_c_ff       <= ncet_pkg::VERTEX_RESET;
         matrix_row_x_ff   <= ncet_pkg::MATRIX_ROW_X_RESET;
         matrix_row_z_ff   <= ncet_pkg::MATRIX_ROW_Z_RESET;
         neighbor_links_ff <= ncet_pkg::LINKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ncet_pkg::REG_VERTEX_A: begin
               vertex_a_ff <= csr_pwdata[ncet_pkg::VERTEX_BITS-1:0];
            end
            ncet_pkg::REG_VERTEX_B: begin
               vertex_b_ff <= csr_pwdata[ncet_pkg::VERTEX_BITS-1:0];
            end
            ncet_pkg::REG_VERTEX_C: begin
               vertex_c_ff <= csr_pwdata[ncet_pkg::VERTEX_BITS-1:0];
            end
            ncet_pkg::REG_MATRIX_ROW_X: begin
               matrix_row_x_ff <= csr_pwdata[ncet_pkg::MATRIX_BITS-1:0];
            end
            ncet_pkg::REG_MATRIX_ROW_Z: begin
               matrix_row_z_ff <= csr_pwdata[ncet_pkg::MATRIX_BITS-1:0];
            end
            ncet_pkg::REG_NEIGHBOR_LINKS: begin
               neighbor_links_ff <= csr_pwdata[ncet_pkg::LINKS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ncet_pkg::REG_VERTEX_A:       csr_prdata = ncet_pkg::CSR_DATA_BITS'(vertex_a_ff);
         ncet_pkg::REG_VERTEX_B:       csr_prdata = ncet_pkg::CSR_DATA_BITS'(vertex_b_ff);
         ncet_pkg::REG_VERTEX_C:       csr_prdata = ncet_pkg::CSR_DATA_BITS'(vertex_c_ff);
         ncet_pkg::REG_MATRIX_ROW_X:   csr_prdata = ncet_pkg::CSR_DATA_BITS'(matrix_row_x_ff);
         ncet_pkg::REG_MATRIX_ROW_Z:   csr_prdata = ncet_pkg::CSR_DATA_BITS'(matrix_row_z_ff);
         ncet_pkg::REG_NEIGHBOR_LINKS: csr_prdata = ncet_pkg::CSR_DATA_BITS'(neighbor_links_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   assign vertex[0] = vertex_a_ff;
   assign vertex[1] = vertex_b_ff;
   assign vertex[2] = vertex_c_ff;

   for (genvar k = 0; k < ncet_pkg::NUM_AXES; k++) begin : g_axis
      assign point[k] = req_tdata[k*ncet_pkg::POINT_BITS +: ncet_pkg::POINT_BITS];
      assign mat_x[k] = ncet_pkg::mat_entry_type'(
                           matrix_row_x_ff[k*ncet_pkg::MAT_BITS +: ncet_pkg::MAT_BITS]);
      assign mat_z[k] = ncet_pkg::mat_entry_type'(
                           matrix_row_z_ff[k*ncet_pkg::MAT_BITS +: ncet_pkg::MAT_BITS]);
   end

   for (genvar e = 0; e < ncet_pkg::NUM_EDGES; e++) begin : g_link
      assign links[e] = ncet_pkg::link_type'(
                           neighbor_links_ff[e*ncet_pkg::LINK_BITS +: ncet_pkg::LINK_BITS]);
   end

   assign req_tready = advance;

   ncet_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .clock       (clock),
      .reset       (reset),
      .advance_i   (advance),
      .in_valid_i  (req_tvalid),
      .point_i     (point),
      .vertex_i    (vertex),
      .out_valid_o (s1_valid),
      .dx_o        (s1_dx),
      .dz_o        (s1_dz),
      .diff_o      (s1_diff)
   );

   ncet_xform #(.COORD_BITS(COORD_BITS)) u_xform (
      .clock       (clock),
      .reset       (reset),
      .advance_i   (advance),
      .in_valid_i  (s1_valid),
      .dx_i        (s1_dx),
      .dz_i        (s1_dz),
      .diff_i      (s1_diff),
      .mat_x_i     (mat_x),
      .mat_z_i     (mat_z),
      .out_valid_o (s3_valid),
      .t_o         (s3_t),
      .diff_o      (s3_diff)
   );

   ncet_dot #(.COORD_BITS(COORD_BITS)) u_dot (
      .clock       (clock),
      .reset       (reset),
      .advance_i   (advance),
      .in_valid_i  (s3_valid),
      .t_i         (s3_t),
      .diff_i      (s3_diff),
      .links_i     (links),
      .out_valid_o (s6_valid),
      .out_data_o  (s6_data)
   );

   ncet_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .in_valid_i  (s6_valid),
      .in_data_i   (s6_data),
      .in_ready_o  (advance),
      .out_valid_o (rsp_tvalid),
      .out_data_o  (rsp_data),
      .out_ready_i (rsp_tready)
   );

   assign rsp_tdata = {7'b0, rsp_data.neighbor_index, rsp_data.is_out};

endmodule

[tb/navmesh_cell_exit_test_tb.sv]
`timescale 1ns / 1ps
// Testbench for the navigation cell exit test: directed table, then random cells and queries.
module navmesh_cell_exit_test_tb;
   import ncet_pkg::*;

   localparam int RSP_LATENCY  = 6;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int NUM_PHASES   = 10;
   localparam int MAX_REPORTS  = 40;
   localparam int COORD_MAX    = (1 << (POINT_BITS - 1)) - 1;
   localparam int COORD_MIN    = -(1 << (POINT_BITS - 1));
   localparam int MAT_MAX      = (1 << (MAT_BITS - 1)) - 1;
   localparam int MAT_MIN      = -(1 << (MAT_BITS - 1));

   typedef logic [NUM_AXES*POINT_BITS-1:0] point_type;

   typedef struct {
      logic                     is_csr;
      csr_index_type            index;
      logic [CSR_DATA_BITS-1:0] value;
      point_type                point;
      logic                     typed;
      rsp_type                  result;
   } step_row_type;

   localparam rsp_type INSIDE_RSP = '{neighbor_index: NO_NEIGHBOR, is_out: 1'b0};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // point_x, point_y, point_z
   logic [63:0]              req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // is_out, neighbor_index
   logic [23:0]              rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   logic [VERTEX_BITS-1:0] cell_vertex [NUM_EDGES];
   logic [MATRIX_BITS-1:0] cell_row_x;
   logic [MATRIX_BITS-1:0] cell_row_z;
   logic [LINKS_BITS-1:0]  cell_links;

   rsp_type      expected_exits [$];
   step_row_type directed_steps [$];
   int           mismatches  = 0;
   int           cycle_count = 0;
   int           burst_left  = 0;
   int           stall_left  = 0;

   always #1 clock = ~clock;

   navmesh_cell_exit_test DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic point_type pack_point(int x, int y, int z);
      logic [POINT_BITS-1:0] fx, fy, fz;
      fx = x[POINT_BITS-1:0];
      fy = y[POINT_BITS-1:0];
      fz = z[POINT_BITS-1:0];
      return {fz, fy, fx};
   endfunction

   function automatic logic [MATRIX_BITS-1:0] pack_row(int m0, int m1, int m2);
      logic [MAT_BITS-1:0] f0, f1, f2;
      f0 = m0[MAT_BITS-1:0];
      f1 = m1[MAT_BITS-1:0];
      f2 = m2[MAT_BITS-1:0];
      return {f2, f1, f0};
   endfunction

   function automatic int clamp_coord(int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // first edge of AB, BC, CA whose transformed normal faces the point
   function automatic rsp_type cell_exit_of(point_type pt);
      longint  p [NUM_AXES];
      longint  s [NUM_AXES];
      longint  f [NUM_AXES];
      longint  mx [NUM_AXES];
      longint  mz [NUM_AXES];
      longint  t;
      longint  dot;
      logic    found;
      rsp_type r;
      r = INSIDE_RSP;
      found = 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
         p[k]  = $signed(pt[k*POINT_BITS +: POINT_BITS]);
         mx[k] = $signed(cell_row_x[k*MAT_BITS +: MAT_BITS]);
         mz[k] = $signed(cell_row_z[k*MAT_BITS +: MAT_BITS]);
      end
      for (int e = 0; e < NUM_EDGES; e++) begin
         if (!found) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               s[k] = $signed(cell_vertex[e][k*POINT_BITS +: POINT_BITS]);
               f[k] = $signed(cell_vertex[(e + 1) % NUM_EDGES][k*POINT_BITS +: POINT_BITS]);
            end
            dot = 0;
            for (int k = 0; k < NUM_AXES; k++) begin
               t = -(f[2] - s[2]) * mx[k] + (f[0] - s[0]) * mz[k];
               dot += t * (p[k] - s[k]);
            end
            if (dot > 0) begin
               found = 1'b1;
               r.is_out = 1'b1;
               r.neighbor_index = cell_links[e*LINK_BITS +: LINK_BITS];
            end
         end
      end
      return r;
   endfunction

   function automatic void add_csr(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
      step_row_type row;
      row = '{is_csr: 1'b1, index: index, value: value, point: '0, typed: 1'b0,
              result: INSIDE_RSP};
      directed_steps.push_back(row);
   endfunction

   function automatic void add_point(point_type pt, logic typed = 1'b0,
                                     rsp_type result = INSIDE_RSP);
      step_row_type row;
      row = '{is_csr: 1'b0, index: REG_VERTEX_A, value: '0, point: pt, typed: typed,
              result: result};
      directed_steps.push_back(row);
   endfunction

   task automatic report(string what);
      if (mismatches < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic csr_write(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, {CSR_INDEX_LSB{1'b0}}};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_VERTEX_A:       cell_vertex[0] = value[VERTEX_BITS-1:0];
         REG_VERTEX_B:       cell_vertex[1] = value[VERTEX_BITS-1:0];
         REG_VERTEX_C:       cell_vertex[2] = value[VERTEX_BITS-1:0];
         REG_MATRIX_ROW_X:   cell_row_x = value[MATRIX_BITS-1:0];
         REG_MATRIX_ROW_Z:   cell_row_z = value[MATRIX_BITS-1:0];
         REG_NEIGHBOR_LINKS: cell_links = value[LINKS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic send_point(point_type pt, logic typed = 1'b0, rsp_type result = INSIDE_RSP);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, pt};
      do @(posedge clock); while (!req_tready);
      expected_exits.push_back(typed ? result : cell_exit_of(pt));
      burst_left--;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_exits.size() != 0) @(posedge clock);
      repeat (2 * RSP_LATENCY) @(posedge clock);
   endtask

   // receiver stalls: free running, sparse short, sparse long, dense single
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         case (cycle_count[9:8])
            2'd1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
            2'd2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 12);
            2'd3: if ($urandom_range(0, 1) == 0) stall_left = 1;
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (expected_exits.size() == 0) begin
            report($sformatf("unexpected beat is_out=%0d neighbor=%0d",
                             got.is_out, got.neighbor_index));
         end else begin
            want = expected_exits.pop_front();
            if (got.is_out !== want.is_out)
               report($sformatf("is_out got %0d want %0d", got.is_out, want.is_out));
            if (got.neighbor_index !== want.neighbor_index)
               report($sformatf("neighbor_index got %0d want %0d",
                                got.neighbor_index, want.neighbor_index));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      step_row_type           row;
      logic [CSR_DATA_BITS-1:0] vtx_word [NUM_EDGES];
      int                     cx, cz, span, x, y, z;
      int                     m [6];
      logic [LINKS_BITS-1:0]  links;
      point_type              pt;

      cell_vertex[0] = VERTEX_RESET;
      cell_vertex[1] = VERTEX_RESET;
      cell_vertex[2] = VERTEX_RESET;
      cell_row_x = MATRIX_ROW_X_RESET;
      cell_row_z = MATRIX_ROW_Z_RESET;
      cell_links = LINKS_RESET;

      // zero cell after reset: every query lies inside
      add_point(pack_point(0, 0, 0), 1'b1, INSIDE_RSP);
      add_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1, INSIDE_RSP);
      add_point(pack_point(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1, INSIDE_RSP);
      add_point(pack_point(COORD_MAX, COORD_MIN, COORD_MAX), 1'b1, INSIDE_RSP);
      add_point(pack_point(COORD_MIN, COORD_MAX, COORD_MIN), 1'b1, INSIDE_RSP);

      // plain triangle, unit matrix: inside, each edge, vertices, on an edge
      add_csr(REG_VERTEX_A, {1'b0, pack_point(0, 0, 0)});
      add_csr(REG_VERTEX_B, {1'b0, pack_point(2560, 0, 0)});
      add_csr(REG_VERTEX_C, {1'b0, pack_point(0, 0, -2560)});
      add_csr(REG_MATRIX_ROW_X, {10'd0, pack_row(65536, 0, 0)});
      add_csr(REG_MATRIX_ROW_Z, {10'd0, pack_row(0, 0, 65536)});
      add_csr(REG_NEIGHBOR_LINKS, {16'd0, 16'd9, 16'd7, 16'd5});
      add_point(pack_point(853, 0, -853));
      add_point(pack_point(100, 0, 100));
      add_point(pack_point(3000, 0, -1000));
      add_point(pack_point(-100, 0, -100));
      add_point(pack_point(0, 0, 0));
      add_point(pack_point(2560, 0, 0));
      add_point(pack_point(1000, 0, 0));
      add_point(pack_point(-100, 0, 100));
      add_point(pack_point(853, COORD_MAX, -853));

      // degenerate edge, out-of-range links, bits above width, unused addresses
      add_csr(REG_NEIGHBOR_LINKS, {16'hABCD, 16'hFFFE, 16'h7FFF, 16'h8000});
      add_csr(REG_VERTEX_B, {1'b1, pack_point(0, 0, 0)});
      add_csr(REG_NEIGHBOR_LINKS + 3'd1, '1);
      add_csr(REG_NEIGHBOR_LINKS + 3'd2, '1);
      add_point(pack_point(100, 0, 100));
      add_point(pack_point(-100, 0, -100));
      add_point(pack_point(0, 0, 0));

      // extreme vertices and matrix entries
      add_csr(REG_MATRIX_ROW_X, {10'h3FF, pack_row(MAT_MIN, MAT_MIN, MAT_MIN)});
      add_csr(REG_MATRIX_ROW_Z, {10'h3FF, pack_row(MAT_MAX, MAT_MAX, MAT_MAX)});
      add_csr(REG_VERTEX_A, {1'b0, pack_point(COORD_MIN, COORD_MAX, COORD_MIN)});
      add_csr(REG_VERTEX_C, {1'b1, pack_point(COORD_MAX, COORD_MIN, COORD_MAX)});
      add_point(pack_point(COORD_MAX, COORD_MIN, COORD_MAX));
      add_point(pack_point(COORD_MIN, COORD_MAX, COORD_MIN));
      add_point(pack_point(0, 0, 0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.is_csr) begin
            drain();
            csr_write(row.index, row.value);
         end else begin
            send_point(row.point, row.typed, row.result);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         cx = int'($urandom_range(0, 1600000)) - 800000;
         cz = int'($urandom_range(0, 1600000)) - 800000;
         span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100000) : $urandom_range(1, 2000);
         for (int v = 0; v < NUM_EDGES; v++) begin
            if (phase == 0) begin
               x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               z = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end else begin
               x = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
               y = $urandom;
               z = clamp_coord(cz + int'($urandom_range(0, 2 * span)) - span);
            end
            vtx_word[v] = {1'($urandom), pack_point(x, y, z)};
         end
         for (int k = 0; k < 6; k++) begin
            if (phase == 0) m[k] = $urandom_range(0, 1) ? MAT_MAX : MAT_MIN;
            else if (phase == 1) m[k] = 0;
            else m[k] = $urandom;
         end
         for (int e = 0; e < NUM_EDGES; e++)
            links[e*LINK_BITS +: LINK_BITS] = ($urandom_range(0, 3) == 0) ? NO_NEIGHBOR
                                                                          : 16'($urandom);
         csr_write(REG_VERTEX_A, vtx_word[0]);
         csr_write(REG_VERTEX_B, vtx_word[1]);
         csr_write(REG_VERTEX_C, vtx_word[2]);
         csr_write(REG_MATRIX_ROW_X, {10'($urandom), pack_row(m[0], m[1], m[2])});
         csr_write(REG_MATRIX_ROW_Z, {10'($urandom), pack_row(m[3], m[4], m[5])});
         csr_write(REG_NEIGHBOR_LINKS, {16'($urandom), links});
         for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
            if (phase == 0 || $urandom_range(0, 7) == 0)
               pt = pack_point($urandom, $urandom, $urandom);
            else
               pt = pack_point(clamp_coord(cx + int'($urandom_range(0, 4 * span)) - 2 * span),
                               $urandom,
                               clamp_coord(cz + int'($urandom_range(0, 4 * span)) - 2 * span));
            send_point(pt);
         end
      end

      drain();
      if (mismatches == 0 && expected_exits.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
